/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// depends on nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

/* rtl/cnh_pkg.sv */
// types and constants of the coordination number histogram
// depends on nothing
`default_nettype none
package cnh_pkg;
	localparam int NUM_SPECIES = 8;
	localparam int MAX_CN = 32;
	localparam int COUNT_BITS = 24;
	localparam int NBINS = MAX_CN + 1;
	localparam int SP_W = $clog2(NUM_SPECIES) > 0 ? $clog2(NUM_SPECIES) : 1;
	localparam int PAIR_W = 2 * SP_W;
	localparam int NPAIRS = NUM_SPECIES * NUM_SPECIES;
	localparam int BIN_W = $clog2(NBINS);
	localparam int ADDR_W = PAIR_W + BIN_W;
	localparam int DEPTH = NPAIRS * (1 << BIN_W);
	localparam int CLR_W = ADDR_W + 1;
	localparam int CNT_W = 30;
	localparam int SUM_W = COUNT_BITS + PAIR_W + 1;

	localparam logic [1:0] MODE_REC = 2'd0;
	localparam logic [1:0] MODE_QUERY = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	typedef struct packed {
		logic load;       // capture input transaction
		logic tally;      // add record to tallies
		logic fin_rd;     // read bin for current finish species
		logic fin_wr;     // write incremented bin
		logic fin_next;   // advance finish species
		logic tally_clr;  // zero tallies
		logic q_rd;       // issue query read for current pair
		logic q_acc;      // accumulate read data
		logic q_next;     // advance query pair
		logic q_done;     // present result
		logic clr_step;   // clear one entry
		logic clr_start;  // begin clearing pass
	} cnh_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic last;
		logic cen_ok;
		logic fin_last;   // current finish species is the final one
		logic q_last;     // current query pair is the final one
		logic clr_last;
	} cnh_sts_t;
endpackage
`default_nettype wire

/* rtl/cnh_datapath.sv */
// datapath: tallies, histogram memory, seen flags, query accumulator
// depends on cnh_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module cnh_datapath import cnh_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [1:0] mode,
	input  wire logic [3:0] central_species,
	input  wire logic [3:0] neighbor_species,
	input  wire logic last_of_atom,
	input  wire logic [5:0] bin_index,
	input  wire cnh_cmd_t cmd,
	output cnh_sts_t sts,
	output logic [CNT_W-1:0] bin_count,
	output logic present,
	output logic [5:0] bins_in_use
);
	logic [1:0] mode_q;
	logic [3:0] cen_q, nb_q;
	logic last_q;
	logic [5:0] bin_q;
	logic [5:0] tally_q [NUM_SPECIES];
	logic [NPAIRS-1:0] seen_q;
	logic [5:0] largest_q;
	logic [SP_W-1:0] fin_q;
	logic [PAIR_W-1:0] qp_q;
	logic [SUM_W-1:0] sum_q;
	logic [COUNT_BITS-1:0] mem [DEPTH];
	logic [COUNT_BITS-1:0] rd_q;
	logic [CLR_W-1:0] clr_q;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic wr_en;
	logic [COUNT_BITS-1:0] wr_data;
	logic cen_ok, nb_ok, bin_ok, any_c, any_n;
	logic [SP_W-1:0] cen_idx, nb_idx;
	logic [5:0] cur_t;
	logic [PAIR_W-1:0] pair_sel;
	logic [SUM_W-1:0] sum_nx;

	assign cen_ok = cen_q < 4'(NUM_SPECIES);
	assign nb_ok = nb_q < 4'(NUM_SPECIES);
	assign bin_ok = bin_q < 6'(NBINS);
	assign any_c = !cen_ok;
	assign any_n = !nb_ok;
	assign cen_idx = cen_q[SP_W-1:0];
	assign nb_idx = nb_q[SP_W-1:0];
	assign cur_t = tally_q[fin_q];

	always_comb begin
		if (any_c) pair_sel = qp_q;
		else if (any_n) pair_sel = {cen_idx, qp_q[SP_W-1:0]};
		else pair_sel = {cen_idx, nb_idx};
	end

	always_comb begin
		if (cmd.fin_rd) rd_addr = {cen_idx, fin_q, cur_t[BIN_W-1:0]};
		else rd_addr = {pair_sel, bin_q[BIN_W-1:0]};
		if (cmd.clr_step) begin
			wr_en = 1'b1;
			wr_addr = clr_q[ADDR_W-1:0];
			wr_data = '0;
		end else begin
			wr_en = cmd.fin_wr && cur_t != 6'd0;
			wr_addr = {cen_idx, fin_q, cur_t[BIN_W-1:0]};
			wr_data = (&rd_q) ? rd_q : rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
		if (cmd.load) begin
			mode_q <= mode;
			cen_q <= central_species;
			nb_q <= neighbor_species;
			last_q <= last_of_atom;
			bin_q <= bin_index;
		end
	end

	assign sum_nx = sum_q + (bin_ok ? SUM_W'(rd_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SPECIES; i++) tally_q[i] <= '0;
			seen_q <= '0;
			largest_q <= '0;
			fin_q <= '0;
			qp_q <= '0;
			sum_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.tally_clr || cmd.clr_start) begin
				for (int i = 0; i < NUM_SPECIES; i++) tally_q[i] <= '0;
			end else if (cmd.tally && nb_ok && tally_q[nb_idx] < 6'(MAX_CN))
				tally_q[nb_idx] <= tally_q[nb_idx] + 6'd1;
			if (cmd.fin_wr && cur_t != 6'd0) begin
				seen_q[{cen_idx, fin_q}] <= 1'b1;
				if (cur_t > largest_q) largest_q <= cur_t;
			end
			if (cmd.fin_next) fin_q <= fin_q + 1'b1;
			if (cmd.tally_clr) fin_q <= '0;
			if (cmd.load) begin
				qp_q <= '0;
				sum_q <= '0;
			end
			if (cmd.q_acc) sum_q <= sum_nx;
			if (cmd.q_next) qp_q <= qp_q + 1'b1;
			if (cmd.clr_start) begin
				clr_q <= '0;
				seen_q <= '0;
				largest_q <= '0;
			end
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
		end
	end

	logic pres;
	always_comb begin
		pres = 1'b0;
		if (any_c) pres = 1'b1;
		else if (any_n) begin
			for (int n = 0; n < NUM_SPECIES; n++)
				if (seen_q[{cen_idx, SP_W'(n)}]) pres = 1'b1;
		end else pres = seen_q[{cen_idx, nb_idx}];
	end

	always_ff @(posedge clk) begin
		if (cmd.q_done) begin
			bin_count <= (sum_q > SUM_W'(2**CNT_W - 1)) ? {CNT_W{1'b1}} : CNT_W'(sum_q);
			present <= pres;
			bins_in_use <= (largest_q > 6'd60) ? 6'd63 : largest_q + 6'd3;
		end
	end

	assign sts.mode = mode_q;
	assign sts.last = last_q;
	assign sts.cen_ok = cen_ok;
	assign sts.fin_last = fin_q == SP_W'(NUM_SPECIES - 1);
	assign sts.q_last = any_c ? (qp_q == PAIR_W'(NPAIRS - 1))
		: any_n ? (qp_q[SP_W-1:0] == SP_W'(NUM_SPECIES - 1)) : 1'b1;
	assign sts.clr_last = clr_q == CLR_W'(DEPTH - 1);

	`ASSERT_NEXT(a_clr_seen, clk, arst_n, cmd.clr_start, seen_q == '0)
	`ASSERT_IMPL(a_largest_bound, clk, arst_n, 1'b1, largest_q <= 6'(MAX_CN))
	`ASSERT_NEXT(a_tally_zero, clk, arst_n, cmd.tally_clr, tally_q[0] == 6'd0)
endmodule
`default_nettype wire

/* rtl/cnh_ctrl.sv */
// controller state machine sequencing records, atom finish, queries and clearing
// depends on cnh_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module cnh_ctrl import cnh_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cnh_sts_t sts,
	output cnh_cmd_t cmd,
	output logic busy,
	output logic done
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DEC   = 8'b0000_0010,
		S_FRD   = 8'b0000_0100,
		S_FWR   = 8'b0000_1000,
		S_QRD   = 8'b0001_0000,
		S_QACC  = 8'b0010_0000,
		S_QOUT  = 8'b0100_0000,
		S_CLR   = 8'b1000_0000
	} state_t;
	state_t state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		busy = state_q != S_IDLE;
		unique case (state_q)
			S_IDLE: if (start) begin
				cmd.load = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				case (sts.mode)
					MODE_REC: begin
						cmd.tally = 1'b1;
						if (sts.last && sts.cen_ok) state_d = S_FRD;
						else begin
							cmd.tally_clr = sts.last;
							state_d = S_IDLE;
						end
					end
					MODE_QUERY: state_d = S_QRD;
					MODE_CLEAR: begin
						cmd.clr_start = 1'b1;
						state_d = S_CLR;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_FRD: begin
				cmd.fin_rd = 1'b1;
				state_d = S_FWR;
			end
			S_FWR: begin
				cmd.fin_wr = 1'b1;
				if (sts.fin_last) begin
					cmd.tally_clr = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.fin_next = 1'b1;
					state_d = S_FRD;
				end
			end
			S_QRD: begin
				cmd.q_rd = 1'b1;
				state_d = S_QACC;
			end
			S_QACC: begin
				cmd.q_acc = 1'b1;
				if (sts.q_last) begin
					state_d = S_QOUT;
				end else begin
					cmd.q_next = 1'b1;
					state_d = S_QRD;
				end
			end
			S_QOUT: begin
				cmd.q_done = 1'b1;
				state_d = S_IDLE;
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= cmd.q_done;
		end
	end

	`ASSERT_IMPL(a_no_load_busy, clk, arst_n, cmd.load, state_q == S_IDLE)
	`ASSERT_NEXT(a_done_after_out, clk, arst_n, state_q == S_QOUT, done)
	`ASSERT_IMPL(a_done_idle, clk, arst_n, done, state_q == S_IDLE)
endmodule
`default_nettype wire

/* rtl/coordination_number_histogram.sv */
// top level of the coordination number histogram
// depends on cnh_pkg, cnh_ctrl and cnh_datapath
`default_nettype none
// usage:
// a transaction is taken at a rising edge with start high and busy low.
// mode 0 is a neighbor record, mode 1 a query, mode 2 clears, mode 3 does nothing.
// only a query gives a result: bin_count, present and bins_in_use are valid
// for exactly one cycle while done is high; the receiver cannot stall it.
// a record without last_of_atom only tallies; a record that ends an atom
// with a valid central species then steps through all NUM_SPECIES species,
// one histogram read and, for a nonzero tally, one write per species.
// a pair query reads one pair, a species-any query NUM_SPECIES pairs,
// an any-any query NUM_SPECIES^2 pairs, one bin read per pair.
// a clear zeroes all DEPTH memory words, one memory word zeroed per cycle.
// after reset the same clearing pass runs with busy
// high before the first transaction is taken.
module coordination_number_histogram import cnh_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic [1:0] mode,
	input  wire logic [3:0] central_species,
	input  wire logic [3:0] neighbor_species,
	input  wire logic last_of_atom,
	input  wire logic [5:0] bin_index,
	output logic done,
	output logic [29:0] bin_count,
	output logic present,
	output logic [5:0] bins_in_use
);
	cnh_cmd_t cmd;
	cnh_sts_t sts;

	cnh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts),
		.cmd(cmd), .busy(busy), .done(done)
	);

	cnh_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .mode(mode),
		.central_species(central_species), .neighbor_species(neighbor_species),
		.last_of_atom(last_of_atom), .bin_index(bin_index),
		.cmd(cmd), .sts(sts), .bin_count(bin_count), .present(present),
		.bins_in_use(bins_in_use)
	);
endmodule
`default_nettype wire
